/* sv/ctvc_pkg.sv */
package ctvc_pkg;

  localparam int unsigned YearBase   = 1900;
  localparam int unsigned YearMax    = 9999;
  localparam int unsigned DayMax     = 31;
  localparam int unsigned MonthMax   = 12;
  localparam int unsigned HourLimit  = 24;
  localparam int unsigned MinLimit   = 60;
  localparam int unsigned YearDrift  = 365 % 7;
  localparam int unsigned Cent       = 100;
  localparam int unsigned QuadCent   = 400;

  // x / 100 == (x * Div100Mul) >> Div100Sh, exact for x below 43690
  localparam int unsigned Div100Sh   = 19;
  localparam int unsigned Div100Mul  = (1 << Div100Sh) / Cent + 1;

  localparam int unsigned YearW      = 14;  // years up to 9999
  localparam int unsigned DaysW      = 15;  // weekday day count

  // Daylight flag codes (bit0 adjust, bit1 in daylight)
  localparam logic [1:0] DlAdjust    = 2'b01;
  localparam logic [1:0] DlBoth      = 2'b11;

  localparam logic signed [1:0] DstOn    = 2'sd1;
  localparam logic signed [1:0] DstOff   = 2'sd0;
  localparam logic signed [1:0] DstUnkn  = -2'sd1;

  // Days before the start of each zero-based month
  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] mi);
    logic [8:0] d;
    logic [8:0] adj;
    adj = {8'd0, leap};
    unique case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59  + adj;
      4'd3:    d = 9'd90  + adj;
      4'd4:    d = 9'd120 + adj;
      4'd5:    d = 9'd151 + adj;
      4'd6:    d = 9'd181 + adj;
      4'd7:    d = 9'd212 + adj;
      4'd8:    d = 9'd243 + adj;
      4'd9:    d = 9'd273 + adj;
      4'd10:   d = 9'd304 + adj;
      4'd11:   d = 9'd334 + adj;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Remainder by 7: fold octal digits (8 = 1 mod 7), then one correction
  function automatic logic [2:0] mod7(input logic [DaysW-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
       + {3'd0, x[14:12]};
    s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
    r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    return r[2:0];
  endfunction

endpackage

/* sv/calendar_time_validate_convert.sv */
// Calendar time check and conversion. Pulse start_i with a raw calendar time
// (year, month, day, hour, minute, second, daylight flags); busy_o stays low,
// so a new beat may be offered on every clock. Each beat yields one result
// beat on done_o, registered through the four register ranks of the pipe
// (input, quotient, day count, result). The receiver cannot stall: a result
// is shown for one cycle only and must be caught then. time_valid_o is high
// when second < 60, minute < 60, hour < 24, day 1..31, month 1..12 and year
// 1900..9999; otherwise every other output field reads zero. The day is not
// checked against the length of its month, so year_day_o simply runs on
// from the start of the month. Weekday counts Sunday as 0; dst_state_o is 1
// with both daylight flags, 0 with only the adjust flag, -1 otherwise.
module calendar_time_validate_convert (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [15:0]       raw_year_i,
  input  logic [7:0]        raw_month_i,
  input  logic [7:0]        raw_day_i,
  input  logic [7:0]        raw_hour_i,
  input  logic [7:0]        raw_minute_i,
  input  logic [7:0]        raw_second_i,
  input  logic [7:0]        daylight_bits_i,
  output logic              done_o,
  output logic              time_valid_o,
  output logic [5:0]        seconds_o,
  output logic [5:0]        minutes_o,
  output logic [4:0]        hours_o,
  output logic [4:0]        month_day_o,
  output logic [3:0]        month_index_o,
  output logic [12:0]       years_since_1900_o,
  output logic [8:0]        year_day_o,
  output logic [2:0]        week_day_o,
  output logic signed [1:0] dst_state_o
);
  import ctvc_pkg::*;

  // ---------------------------------------------------------------- stage A
  // Capture the raw beat.
  logic        a_vld_q;
  logic [15:0] a_year_q;
  logic [7:0]  a_month_q, a_day_q, a_hour_q, a_min_q, a_sec_q;
  logic [1:0]  a_dl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_year_q  <= raw_year_i;
      a_month_q <= raw_month_i;
      a_day_q   <= raw_day_i;
      a_hour_q  <= raw_hour_i;
      a_min_q   <= raw_minute_i;
      a_sec_q   <= raw_second_i;
      a_dl_q    <= daylight_bits_i[1:0];
    end
  end

  assign busy_o = 1'b0;

  // Range checks and (year - 1) / 100 by reciprocal multiply.
  logic              a_ok;
  logic [YearW-1:0]  a_ym1;
  logic [YearW+13:0] a_prod;
  logic [YearW-1:0]  a_q100;

  always_comb begin
    a_ok = (a_sec_q  < 8'(MinLimit)) && (a_min_q < 8'(MinLimit)) &&
           (a_hour_q < 8'(HourLimit)) &&
           (a_day_q  >= 8'd1) && (a_day_q <= 8'(DayMax)) &&
           (a_month_q >= 8'd1) && (a_month_q <= 8'(MonthMax)) &&
           (a_year_q >= 16'(YearBase)) && (a_year_q <= 16'(YearMax));
    // Only meaningful for an in-range year, which fits YearW bits.
    a_ym1  = a_year_q[YearW-1:0] - YearW'(1);
    a_prod = {14'd0, a_ym1} * (YearW + 14)'(Div100Mul);
    a_q100 = YearW'(a_prod >> Div100Sh);
  end

  // ---------------------------------------------------------------- stage B
  logic             b_vld_q, b_ok_q;
  logic [YearW-1:0] b_year_q, b_ym1_q, b_q100_q;
  logic [3:0]       b_mi_q;
  logic [4:0]       b_day_q, b_hour_q;
  logic [5:0]       b_min_q, b_sec_q;
  logic [1:0]       b_dl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_ok_q   <= a_ok;
      b_year_q <= a_year_q[YearW-1:0];
      b_ym1_q  <= a_ym1;
      b_q100_q <= a_q100;
      b_mi_q   <= a_month_q[3:0] - 4'd1;
      b_day_q  <= a_day_q[4:0];
      b_hour_q <= a_hour_q[4:0];
      b_min_q  <= a_min_q[5:0];
      b_sec_q  <= a_sec_q[5:0];
      b_dl_q   <= a_dl_q;
    end
  end

  // Leap test from the remainder of (year - 1) by 100: a remainder of 99
  // marks a century year, which is leap only when year / 100 is a multiple
  // of four, i.e. (year - 1) / 100 ends in binary 11.
  logic [YearW-1:0] b_rem100;
  logic             b_cent, b_leap;
  logic [8:0]       b_yday;
  logic [DaysW-1:0] b_ndays;

  always_comb begin
    b_rem100 = b_ym1_q - YearW'(b_q100_q * YearW'(Cent));
    b_cent   = (b_rem100 == YearW'(Cent - 1));
    b_leap   = ((b_year_q[1:0] == 2'b00) && !b_cent) ||
               (b_cent && (b_q100_q[1:0] == 2'b11));
    b_yday   = days_before(b_leap, b_mi_q) + {4'd0, b_day_q} - 9'd1;
    // One day of drift per year, plus leap days before this year.
    // (year - 1) / 400 is the quotient by 100 shifted down by two.
    b_ndays  = DaysW'(b_year_q * YearW'(YearDrift))
             + DaysW'(b_ym1_q >> 2)
             - DaysW'(b_q100_q)
             + DaysW'(b_q100_q >> $clog2(QuadCent / Cent))
             + DaysW'(b_yday);
  end

  // ---------------------------------------------------------------- stage C
  logic             c_vld_q, c_ok_q;
  logic [DaysW-1:0] c_ndays_q;
  logic [8:0]       c_yday_q;
  logic [12:0]      c_years_q;
  logic [3:0]       c_mi_q;
  logic [4:0]       c_day_q, c_hour_q;
  logic [5:0]       c_min_q, c_sec_q;
  logic [1:0]       c_dl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      c_ok_q    <= b_ok_q;
      c_ndays_q <= b_ndays;
      c_yday_q  <= b_yday;
      c_years_q <= 13'(b_year_q - YearW'(YearBase));
      c_mi_q    <= b_mi_q;
      c_day_q   <= b_day_q;
      c_hour_q  <= b_hour_q;
      c_min_q   <= b_min_q;
      c_sec_q   <= b_sec_q;
      c_dl_q    <= b_dl_q;
    end
  end

  logic signed [1:0] c_dst;
  always_comb begin
    priority if (c_dl_q == DlBoth) begin
      c_dst = DstOn;
    end else if (c_dl_q == DlAdjust) begin
      c_dst = DstOff;
    end else begin
      c_dst = DstUnkn;
    end
  end

  // ---------------------------------------------------------------- result
  // Zero every field of an invalid time.
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_vld_q) begin
      time_valid_o       <= c_ok_q;
      seconds_o          <= c_ok_q ? c_sec_q   : '0;
      minutes_o          <= c_ok_q ? c_min_q   : '0;
      hours_o            <= c_ok_q ? c_hour_q  : '0;
      month_day_o        <= c_ok_q ? c_day_q   : '0;
      month_index_o      <= c_ok_q ? c_mi_q    : '0;
      years_since_1900_o <= c_ok_q ? c_years_q : '0;
      year_day_o         <= c_ok_q ? c_yday_q  : '0;
      week_day_o         <= c_ok_q ? mod7(c_ndays_q) : '0;
      dst_state_o        <= c_ok_q ? c_dst     : DstOff;
    end
  end

  assign done_o = done_q;

endmodule

/* sv/ctvc_checker.sv */
module ctvc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic              time_valid_o,
  input logic [5:0]        seconds_o,
  input logic [5:0]        minutes_o,
  input logic [4:0]        hours_o,
  input logic [4:0]        month_day_o,
  input logic [3:0]        month_index_o,
  input logic [12:0]       years_since_1900_o,
  input logic [8:0]        year_day_o,
  input logic [2:0]        week_day_o,
  input logic signed [1:0] dst_state_o
);

  // Every taken beat comes back as a result beat.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("result beat missing");

  // No result beat without a matching beat taken earlier.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("unexpected result beat");

  // Invalid time shows all fields zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !time_valid_o) |->
      (seconds_o == 6'd0 && minutes_o == 6'd0 && hours_o == 5'd0 &&
       month_day_o == 5'd0 && month_index_o == 4'd0 &&
       years_since_1900_o == 13'd0 && year_day_o == 9'd0 &&
       week_day_o == 3'd0 && dst_state_o == 2'sd0))
    else $error("invalid time with nonzero fields");

  // Valid time stays within calendar ranges.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && time_valid_o) |->
      (week_day_o < 3'd7 && month_index_o < 4'd12 && year_day_o <= 9'd365 &&
       month_day_o != 5'd0 && hours_o < 5'd24 && dst_state_o != -2'sd2))
    else $error("converted field out of range");

endmodule

bind calendar_time_validate_convert ctvc_checker u_ctvc_checker (.*);

/* test/tb_calendar_time_validate_convert.sv */
`timescale 1ns / 100ps

// Stimulus and checking for the calendar time checker. A driver offers time
// beats from a queue at the falling edge, with random gaps or back to back; a
// monitor at the rising edge predicts the broken-down time for every beat
// taken and compares each result beat with the oldest prediction.
module tb_calendar_time_validate_convert;
  import ctvc_pkg::*;

  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned RandomBeats = 500;
  localparam int unsigned MaxGap      = 5;
  localparam int unsigned DrainCycles = 8;      // pipe is four deep, allow slack
  localparam int unsigned CycleLimit  = 60000;  // watchdog bound for a hung run

  // Days before each month in a common year; a leap day shifts March onwards.
  localparam int unsigned CumDays [12] = '{0, 31, 59, 90, 120, 151, 181, 212,
                                           243, 273, 304, 334};
  // Years around the leap-rule boundaries and the range ends.
  localparam int unsigned EdgeYears [10] = '{1900, 1901, 1904, 1999, 2000,
                                             2001, 2100, 2400, 9998, 9999};

  typedef struct {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [7:0]  dl_bits;
    int unsigned gap;       // idle cycles before this beat is offered
  } cal_beat_t;

  typedef struct {
    logic              valid;
    logic [5:0]        sec;
    logic [5:0]        min;
    logic [4:0]        hour;
    logic [4:0]        mday;
    logic [3:0]        mon;
    logic [12:0]       year;
    logic [8:0]        yday;
    logic [2:0]        wday;
    logic signed [1:0] dst;
  } broken_time_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  cal_beat_t driven = '{default: '0};

  logic              busy_o;
  logic              done_o;
  logic              time_valid_o;
  logic [5:0]        seconds_o;
  logic [5:0]        minutes_o;
  logic [4:0]        hours_o;
  logic [4:0]        month_day_o;
  logic [3:0]        month_index_o;
  logic [12:0]       years_since_1900_o;
  logic [8:0]        year_day_o;
  logic [2:0]        week_day_o;
  logic signed [1:0] dst_state_o;

  cal_beat_t    pending_times[$];
  broken_time_t expected_tm[$];
  int unsigned  beats_sent = 0;
  int unsigned  beats_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  bit           quiet = 1'b0;   // when set, queue beats back to back

  calendar_time_validate_convert DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .raw_year_i         (driven.year),
    .raw_month_i        (driven.month),
    .raw_day_i          (driven.day),
    .raw_hour_i         (driven.hour),
    .raw_minute_i       (driven.minute),
    .raw_second_i       (driven.second),
    .daylight_bits_i    (driven.dl_bits),
    .done_o             (done_o),
    .time_valid_o       (time_valid_o),
    .seconds_o          (seconds_o),
    .minutes_o          (minutes_o),
    .hours_o            (hours_o),
    .month_day_o        (month_day_o),
    .month_index_o      (month_index_o),
    .years_since_1900_o (years_since_1900_o),
    .year_day_o         (year_day_o),
    .week_day_o         (week_day_o),
    .dst_state_o        (dst_state_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Hold reset for a fixed count of cycles, release it once and for all.
  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Broken-down time of one calendar time. Any field out of range clears
  // the whole result, the daylight state included.
  function automatic broken_time_t convert_calendar(cal_beat_t c);
    broken_time_t t;
    int unsigned  yr;
    int unsigned  ym1;
    int unsigned  yday;
    int unsigned  ndays;
    logic         leap;
    t = '{default: '0};
    if (c.second < MinLimit && c.minute < MinLimit && c.hour < HourLimit &&
        c.day >= 1 && c.day <= DayMax && c.month >= 1 && c.month <= MonthMax &&
        c.year >= YearBase && c.year <= YearMax) begin
      yr   = c.year;
      ym1  = yr - 1;
      leap = (yr % 4 == 0 && yr % Cent != 0) || (yr % QuadCent == 0);
      // the day may run past the end of its month: no clamp here
      yday = CumDays[c.month - 1] + c.day - 1 + ((leap && c.month > 2) ? 1 : 0);
      // each year drifts the weekday by one, each leap day by one more
      ndays = yr * YearDrift + ym1 / 4 - ym1 / Cent + ym1 / QuadCent + yday;
      t.valid = 1'b1;
      t.sec   = c.second[5:0];
      t.min   = c.minute[5:0];
      t.hour  = c.hour[4:0];
      t.mday  = c.day[4:0];
      t.mon   = 4'(c.month - 1);
      t.year  = 13'(yr - YearBase);
      t.yday  = 9'(yday);
      t.wday  = 3'(ndays % 7);
      // only the two low flag bits count
      case (c.dl_bits[1:0])
        DlBoth:   t.dst = DstOn;
        DlAdjust: t.dst = DstOff;
        default:  t.dst = DstUnkn;
      endcase
    end
    return t;
  endfunction

  task automatic queue_time(input int unsigned year, input int unsigned month,
                            input int unsigned day, input int unsigned hour,
                            input int unsigned minute, input int unsigned second,
                            input int unsigned dl_bits);
    cal_beat_t c;
    c.year    = 16'(year);
    c.month   = 8'(month);
    c.day     = 8'(day);
    c.hour    = 8'(hour);
    c.minute  = 8'(minute);
    c.second  = 8'(second);
    c.dl_bits = 8'(dl_bits);
    c.gap     = quiet ? 0 : $urandom_range(0, MaxGap);
    pending_times.push_back(c);
  endtask

  // Compare one result field; X or Z on the port counts as a mismatch.
  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: hold a beat until it is taken, then wait out the next beat's gap
  // and offer it. start_i gets one assignment per edge, so a beat that follows
  // with no gap simply keeps it high.
  always @(negedge clk_i) begin
    static int unsigned gap_left = 0;
    static bit          gap_loaded = 1'b0;
    if (rst_ni && !(start_i && beats_taken != beats_sent)) begin
      if (!gap_loaded && pending_times.size() > 0) begin
        gap_left   = pending_times[0].gap;
        gap_loaded = 1'b1;
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_times.size() > 0) begin
        driven     <= pending_times.pop_front();
        start_i    <= 1'b1;
        gap_loaded  = 1'b0;
        beats_sent++;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check result beats against the oldest prediction, then record
  // a prediction for any time beat taken at this edge.
  always @(posedge clk_i) begin
    broken_time_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_tm.size() == 0) begin
          $error("result beat with no conversion outstanding");
          mismatches++;
        end else begin
          want = expected_tm.pop_front();
          check_field("time_valid", want.valid, time_valid_o);
          check_field("seconds", want.sec, seconds_o);
          check_field("minutes", want.min, minutes_o);
          check_field("hours", want.hour, hours_o);
          check_field("month_day", want.mday, month_day_o);
          check_field("month_index", want.mon, month_index_o);
          check_field("years_since_1900", want.year, years_since_1900_o);
          check_field("year_day", want.yday, year_day_o);
          check_field("week_day", want.wday, week_day_o);
          check_field("dst_state", want.dst, dst_state_o);
        end
      end
      if (start_i && !busy_o) begin
        expected_tm.push_back(convert_calendar(driven));
        beats_taken++;
      end
    end
  end

  // Watchdog: give up on a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;

    // Range ends, the leap rules, days past the month end, the daylight
    // codes with stray upper bits, and each field just out of range.
    queue_time(1900, 1, 1, 0, 0, 0, 3);
    queue_time(9999, 12, 31, 23, 59, 59, 3);
    queue_time(2000, 2, 29, 12, 30, 30, 1);
    queue_time(2000, 3, 1, 0, 0, 0, 0);
    queue_time(1900, 3, 1, 6, 7, 8, 2);
    queue_time(2024, 12, 31, 23, 59, 59, 'hFF);
    queue_time(2023, 2, 31, 1, 2, 3, 'hFD);
    queue_time(2023, 4, 31, 4, 5, 6, 'hFC);
    queue_time(2100, 12, 31, 11, 11, 11, 'hFE);
    queue_time(1999, 12, 31, 23, 59, 59, 2);
    queue_time(2023, 6, 15, 10, 20, 60, 3);
    queue_time(2023, 6, 15, 10, 60, 30, 3);
    queue_time(2023, 6, 15, 24, 20, 30, 3);
    queue_time(2023, 6, 0, 10, 20, 30, 3);
    queue_time(2023, 6, 32, 10, 20, 30, 3);
    queue_time(2023, 0, 15, 10, 20, 30, 3);
    queue_time(2023, 13, 15, 10, 20, 30, 3);
    queue_time(1899, 12, 31, 23, 59, 59, 3);
    queue_time(10000, 1, 1, 0, 0, 0, 3);
    queue_time('hFFFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);
    queue_time(0, 0, 0, 0, 0, 0, 0);

    // Mostly well-formed times with random content; the rest break one
    // field or are pure noise. Alternate stretches of back-to-back beats.
    for (int i = 0; i < RandomBeats; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      yr = ($urandom_range(0, 3) == 0) ? EdgeYears[$urandom_range(0, 9)]
                                       : $urandom_range(YearBase, YearMax);
      mo = $urandom_range(1, MonthMax);
      dy = $urandom_range(1, DayMax);
      hr = $urandom_range(0, HourLimit - 1);
      mi = $urandom_range(0, MinLimit - 1);
      se = $urandom_range(0, MinLimit - 1);
      kind = $urandom_range(0, 9);
      if (kind == 7 || kind == 8) begin
        // spoil one field, both below and above where it has a floor
        case ($urandom_range(0, 5))
          0: se = $urandom_range(MinLimit, 255);
          1: mi = $urandom_range(MinLimit, 255);
          2: hr = $urandom_range(HourLimit, 255);
          3: dy = $urandom_range(0, 1) ? 0 : $urandom_range(DayMax + 1, 255);
          4: mo = $urandom_range(0, 1) ? 0 : $urandom_range(MonthMax + 1, 255);
          default: yr = $urandom_range(0, 1) ? $urandom_range(0, YearBase - 1)
                                             : $urandom_range(YearMax + 1, 65535);
        endcase
      end else if (kind == 9) begin
        yr = $urandom_range(0, 65535);
        mo = $urandom_range(0, 255);
        dy = $urandom_range(0, 255);
        hr = $urandom_range(0, 255);
        mi = $urandom_range(0, 255);
        se = $urandom_range(0, 255);
      end
      queue_time(yr, mo, dy, hr, mi, se, $urandom_range(0, 255));
    end

    // Drain: every beat taken, every result back, then a few quiet cycles.
    @(posedge clk_i);
    while (!rst_ni || pending_times.size() != 0 || beats_taken != beats_sent)
      @(posedge clk_i);
    while (expected_tm.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* calendar_time_validate_convert.f */
sv/ctvc_pkg.sv
sv/calendar_time_validate_convert.sv
sv/ctvc_checker.sv
test/tb_calendar_time_validate_convert.sv
